[rtl/bspc_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded stack permutation check: shared definitions
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package bspc_pkg;

   // Width of a label, a count and a configuration register.
   localparam int LABEL_W = 13;
   // The next label to enter can reach one past the largest label.
   localparam int NEXT_W  = LABEL_W + 1;
   // Stream payload widths, padded to whole bytes.
   localparam int TDATA_W = 16;

   // Configuration register indexes.
   localparam logic CSR_SEQUENCE_LENGTH = 1'b0;
   localparam logic CSR_STACK_CAPACITY  = 1'b1;

   // Register reset value before clamping.
   localparam logic [LABEL_W-1:0] CSR_RESET_VALUE = 13'd4096;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP,
      ST_DONE
   } state_type;

endpackage

[rtl/bounded_stack_permutation_check.sv]
// ----------------------------------------------------------------------------
// Bounded stack permutation check
// Checks item by item whether a wanted label order can be made with one
// holding stack of limited capacity.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one wanted label per item, with req_tuser set on
//   the first item of a sequence to restart the check. The rsp_ channel
//   returns one item per request: the number of labels pushed before the pop
//   and a feasible flag that stays low after a failure until the next restart.
//   The csr_ port writes the sequence length and stack capacity; write only
//   while the block is idle. Both are clamped to MAX_LABELS.
// Sequencing:
//   The stack lives in one synchronous RAM. A run of pushes writes one label
//   below the target to the RAM in each PUSH state (the target is popped at
//   once); a pop, failing or not, is checked in the POP state, and a single
//   push or another failure goes straight to DONE. DONE loads the result into
//   the output register; a new item is accepted only back in IDLE.
// Reset:
//   Synchronous, active high. Clears the stack depth, the next label (to 1),
//   the fail flag and the output valid; both registers return to 4096, clamped.
// Stalls:
//   A result waits in the output register while rsp_tready is low; the
//   sequencer may take and finish the next item and then holds its result
//   until the output register frees up.
// ----------------------------------------------------------------------------
module bounded_stack_permutation_check #(
   parameter int MAX_LABELS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel. tdata: target_label [12:0], zero pad [15:13].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bspc_pkg::TDATA_W-1:0]      req_tdata,
   // tuser: first_item [0].
   input  logic                              req_tuser,
   // Response channel. tdata: push_count [12:0], zero pad [15:13].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bspc_pkg::TDATA_W-1:0]      rsp_tdata,
   // tuser: feasible [0].
   output logic                              rsp_tuser,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [bspc_pkg::LABEL_W-1:0]      csr_wdata
);

   localparam int LW = bspc_pkg::LABEL_W;
   localparam int NW = bspc_pkg::NEXT_W;
   localparam int AW = $clog2(MAX_LABELS);
   // Largest value a register may take after clamping.
   localparam logic [LW-1:0] CLAMP_VAL =
      (MAX_LABELS < (1 << LW)) ? LW'(MAX_LABELS) : {LW{1'b1}};

   function automatic logic [LW-1:0] clamp_max(input logic [LW-1:0] v);
      return (v > CLAMP_VAL) ? CLAMP_VAL : v;
   endfunction

   bspc_pkg::state_type state_ff, state_in;

   logic [LW-1:0] seq_len_ff;
   logic [LW-1:0] stack_cap_ff;
   logic [LW-1:0] depth_ff, depth_in;
   logic [NW-1:0] next_ff, next_in;
   logic          failed_ff, failed_in;
   logic [LW-1:0] lab_ff, lab_in;
   logic [LW-1:0] target_ff, target_in;
   logic [LW-1:0] res_count_ff, res_count_in;
   logic          res_feas_ff, res_feas_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_feas_ff, rsp_feas_in;

   // Stack memory and its port signals.
   logic [LW-1:0] stack_mem [MAX_LABELS];
   logic [LW-1:0] rd_q_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   // Item fields and state as seen after an optional restart.
   logic [LW-1:0] req_target;
   logic          eff_failed;
   logic [NW-1:0] eff_next;
   logic [LW-1:0] eff_depth;
   logic [NW-1:0] push_cnt;
   logic          push_fail;

   assign req_target = req_tdata[LW-1:0];
   assign eff_failed = req_tuser ? 1'b0 : failed_ff;
   assign eff_next   = req_tuser ? NW'(1) : next_ff;
   assign eff_depth  = req_tuser ? '0 : depth_ff;

   // Labels pushed for this target, the target itself included.
   assign push_cnt  = {1'b0, req_target} - eff_next + NW'(1);
   assign push_fail = (req_target > seq_len_ff) ||
                      (push_cnt > {1'b0, stack_cap_ff}) ||
                      ({1'b0, eff_depth} > ({1'b0, stack_cap_ff} - push_cnt));

   // The write goes to the free slot above the top; the read looks at the top.
   assign wr_addr = AW'(depth_ff);
   assign rd_addr = AW'(depth_ff - LW'(1));

   // Configuration registers, clamped on write.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff   <= clamp_max(bspc_pkg::CSR_RESET_VALUE);
         stack_cap_ff <= clamp_max(bspc_pkg::CSR_RESET_VALUE);
      end else if (csr_we) begin
         unique case (csr_index)
            bspc_pkg::CSR_SEQUENCE_LENGTH: seq_len_ff   <= clamp_max(csr_wdata);
            bspc_pkg::CSR_STACK_CAPACITY:  stack_cap_ff <= clamp_max(csr_wdata);
            default: ;
         endcase
      end
   end

   // Stack RAM: at most one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= lab_ff;
      end
      rd_q_ff <= stack_mem[rd_addr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bspc_pkg::ST_IDLE;
         depth_ff     <= '0;
         next_ff      <= NW'(1);
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         next_ff      <= next_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lab_ff       <= lab_in;
      target_ff    <= target_in;
      res_count_ff <= res_count_in;
      res_feas_ff  <= res_feas_in;
      rsp_count_ff <= rsp_count_in;
      rsp_feas_ff  <= rsp_feas_in;
   end

   // Sequencer: decide on accept, push one label a cycle, check a pop, hand the result on.
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      next_in      = next_ff;
      failed_in    = failed_ff;
      lab_in       = lab_ff;
      target_in    = target_ff;
      res_count_in = res_count_ff;
      res_feas_in  = res_feas_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_feas_in  = rsp_feas_ff;
      wr_en        = 1'b0;
      req_tready   = (state_ff == bspc_pkg::ST_IDLE);

      // The output register empties when its item is taken.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bspc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               depth_in     = eff_depth;
               next_in      = eff_next;
               failed_in    = eff_failed;
               target_in    = req_target;
               res_count_in = '0;
               res_feas_in  = 1'b0;
               priority if (eff_failed) begin
                  state_in = bspc_pkg::ST_DONE;
               end else if ({1'b0, req_target} >= eff_next) begin
                  if (push_fail) begin
                     failed_in = 1'b1;
                     state_in  = bspc_pkg::ST_DONE;
                  end else begin
                     next_in      = {1'b0, req_target} + NW'(1);
                     res_count_in = push_cnt[LW-1:0];
                     res_feas_in  = 1'b1;
                     lab_in       = eff_next[LW-1:0];
                     // The target is pushed and popped at once: only the
                     // labels below it reach the RAM.
                     state_in = (push_cnt == NW'(1)) ? bspc_pkg::ST_DONE
                                                     : bspc_pkg::ST_PUSH;
                  end
               end else begin
                  state_in = bspc_pkg::ST_POP;
               end
            end
         end
         bspc_pkg::ST_PUSH: begin
            wr_en    = 1'b1;
            depth_in = depth_ff + LW'(1);
            lab_in   = lab_ff + LW'(1);
            if (lab_ff + LW'(1) == target_ff) begin
               state_in = bspc_pkg::ST_DONE;
            end
         end
         bspc_pkg::ST_POP: begin
            // The top entry was read on the accept edge.
            if ((depth_ff != '0) && (rd_q_ff == target_ff)) begin
               depth_in    = depth_ff - LW'(1);
               res_feas_in = 1'b1;
            end else begin
               failed_in   = 1'b1;
               res_feas_in = 1'b0;
            end
            res_count_in = '0;
            state_in     = bspc_pkg::ST_DONE;
         end
         bspc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_count_ff;
               rsp_feas_in  = res_feas_ff;
               state_in     = bspc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bspc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bspc_pkg::TDATA_W - LW){1'b0}}, rsp_count_ff};
   assign rsp_tuser  = rsp_feas_ff;

endmodule

[rtl/bspc_checker.sv]
// ----------------------------------------------------------------------------
// Bounded stack permutation check: port checker
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module bspc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bspc_pkg::TDATA_W-1:0]  rsp_tdata,
   input logic                          rsp_tuser
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A failed result never reports pushes.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("failed item reports a push count");

   // The padding above the push count stays zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[bspc_pkg::TDATA_W-1:bspc_pkg::LABEL_W] == '0)
      else $error("response padding is not zero");

   // No result appears in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind bounded_stack_permutation_check bspc_checker u_bspc_checker (.*);
